// File: hw/rtl/mmcs_pkg.sv
// Shared types and constants for the min-max contrast stretch block.
package mmcs_pkg;

    // Input item kinds, carried on s_tuser
    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_MEASURE = 2'd1;
    localparam logic [1:0] MODE_SCALE   = 2'd2;

    // Quotient width and the step counter that walks it
    localparam int QUOT_BITS = 8;
    localparam int CNT_BITS  = 3;

    // Full-scale register reset value
    localparam logic [7:0] FULL_SCALE_RST = 8'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;    // input word taken this cycle
        logic setup;     // form offset, span and range flags
        logic mul;       // form product, load shifted divisor
        logic div_step;  // one restoring divide step
        logic load_out;  // move result into the output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;  // output register empty or draining this cycle
    } sts_t;

endpackage

// File: hw/rtl/mmcs_ctrl.sv
// Controller state machine for the min-max contrast stretch block.
module mmcs_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic [1:0]       s_mode,
    output logic             s_tready,
    input  mmcs_pkg::sts_t   sts,
    output mmcs_pkg::cmd_t   cmd
);
    import mmcs_pkg::*;

    state_t               state_reg, state_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;

    // State and step counter registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_mode == MODE_SCALE) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(QUOT_BITS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_SETUP: begin
                cmd.setup = 1'b1;
            end
            ST_MUL: begin
                cmd.mul = 1'b1;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_DONE: begin
                cmd.load_out = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: hw/rtl/mmcs_dp.sv
// Datapath: min/max tracking, offset multiply, restoring divider, output register.
module mmcs_dp #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [1:0]             s_mode,
    input  logic [PIXEL_BITS-1:0]  s_pixel,
    input  logic                   cfg_wr_en,
    input  logic [7:0]             cfg_wr_data,
    input  mmcs_pkg::cmd_t         cmd,
    output mmcs_pkg::sts_t         sts,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_scaled,
    output logic                   m_clipped,
    output logic                   m_flat
);
    import mmcs_pkg::*;

    localparam int DW = PIXEL_BITS + 1;      // offset and span width
    localparam int PW = PIXEL_BITS + 9;      // product width

    logic signed [PIXEL_BITS-1:0] low_reg, high_reg, x_reg;
    logic signed [PIXEL_BITS-1:0] pix;
    logic [7:0]                   fs_reg;
    logic [DW-1:0]                num_reg, den_reg;
    logic                         flat_reg, below_reg, above_reg;
    logic [PW-1:0]                rem_reg, dsh_reg;
    logic [QUOT_BITS-1:0]         quot_reg;
    logic                         tvalid_reg;
    logic [7:0]                   scaled_reg;
    logic                         clipped_reg, flat_out_reg;
    logic                         ge;
    logic [PW-1:0]                prod;

    assign pix = signed'(s_pixel);
    assign ge  = (rem_reg >= dsh_reg);
    assign prod = PW'(num_reg) * PW'(fs_reg);

    // Full-scale register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fs_reg <= FULL_SCALE_RST;
        end else if (cfg_wr_en) begin
            fs_reg <= cfg_wr_data;
        end
    end

    // Running min and max, captured pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= '0;
            high_reg <= '0;
        end else if (cmd.accept) begin
            case (s_mode)
                MODE_START: begin
                    low_reg  <= pix;
                    high_reg <= pix;
                end
                MODE_MEASURE: begin
                    if (pix < low_reg)  low_reg  <= pix;
                    if (pix > high_reg) high_reg <= pix;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            x_reg <= pix;
        end
    end

    // Offset, span and range flags
    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            num_reg   <= {x_reg[PIXEL_BITS-1], x_reg} - {low_reg[PIXEL_BITS-1], low_reg};
            den_reg   <= {high_reg[PIXEL_BITS-1], high_reg} - {low_reg[PIXEL_BITS-1], low_reg};
            flat_reg  <= !(high_reg > low_reg);
            below_reg <= (x_reg < low_reg);
            above_reg <= (x_reg > high_reg);
        end
    end

    // Product, then one quotient bit per step with the divisor shifted down
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            rem_reg  <= prod;
            dsh_reg  <= PW'(den_reg) << (QUOT_BITS - 1);
            quot_reg <= '0;
        end else if (cmd.div_step) begin
            if (ge) rem_reg <= rem_reg - dsh_reg;
            dsh_reg  <= dsh_reg >> 1;
            quot_reg <= {quot_reg[QUOT_BITS-2:0], ge};
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            flat_out_reg <= flat_reg;
            clipped_reg  <= !flat_reg && (below_reg || above_reg);
            if (flat_reg || below_reg) begin
                scaled_reg <= '0;
            end else if (above_reg) begin
                scaled_reg <= fs_reg;
            end else begin
                scaled_reg <= quot_reg;
            end
        end
    end

    assign sts.out_free = !tvalid_reg || m_tready;
    assign m_tvalid     = tvalid_reg;
    assign m_scaled     = scaled_reg;
    assign m_clipped    = clipped_reg;
    assign m_flat       = flat_out_reg;

endmodule

// File: hw/rtl/min_max_contrast_stretch_top.sv
// Top level of the min-max contrast stretch block.
//
// The host streams a frame twice on the s_ channel. s_tuser carries the item
// kind: start (restarts min and max at the pixel), measure (folds the pixel
// into the running min and max) or scale. s_tdata carries the signed pixel.
// Start and measure words give no result; each scale word gives one result
// word on the m_ channel: m_tdata is floor((x-min)*full_scale/(max-min)),
// saturated to 0..full_scale, with clipped and flat_range flags in m_tuser.
// full_scale is written through cfg_wr_en/cfg_wr_data; the user must do so only
// while idle, as the block does not enforce it. Start and measure words are
// taken back to back while idle. A scale word passes through a setup step, a
// multiply step and eight restoring divide steps, one quotient bit per cycle,
// then the output load; s_tready is low from acceptance until that load, so no
// new word is taken before the previous scale word's result is loaded.
// The result sits in an output register; when the receiver stalls, the next
// start or measure word is still taken, and a scale word finishes and waits
// in its final state until the register drains.
// Synchronous active-low reset clears min and max to 0, full_scale to 100
// and drops m_tvalid.
module min_max_contrast_stretch_top #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((PIXEL_BITS + 7) / 8) * 8-1:0] s_tdata,  // [PIXEL_BITS-1:0] pixel
    input  logic [1:0]                            s_tuser,  // [1:0] mode
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [7:0]                            m_tdata,  // [7:0] scaled
    output logic [1:0]                            m_tuser,  // [0] clipped, [1] flat_range
    input  logic                                  cfg_wr_en,
    input  logic [7:0]                            cfg_wr_data
);
    import mmcs_pkg::*;

    cmd_t cmd;
    sts_t sts;

    mmcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_mode   (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mmcs_dp #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_mode      (s_tuser),
        .s_pixel     (s_tdata[PIXEL_BITS-1:0]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_scaled    (m_tdata),
        .m_clipped   (m_tuser[0]),
        .m_flat      (m_tuser[1])
    );

endmodule
